/* sv/rtfl_pkg.sv */
package rtfl_pkg;

	// Field widths
	localparam int TILE_W     = 10;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int COUNT_W    = 11;
	localparam int CAP_CFG_W  = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd1;

	// Per-cell commands
	localparam logic [2:0] CELL_KEEP   = 3'd0;
	localparam logic [2:0] CELL_NEXT   = 3'd1;
	localparam logic [2:0] CELL_HEAD   = 3'd2;
	localparam logic [2:0] CELL_NEW    = 3'd3;
	localparam logic [2:0] CELL_UNLOCK = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TILE_W-1:0] tile_index;
		logic              lock;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                evicted_valid;
		logic [TILE_W-1:0]   evicted_tile;
	} rsp_t;

	// One queue slot: resident tile and its lock
	typedef struct packed {
		logic [TILE_W-1:0] tile;
		logic              locked;
	} entry_t;

	typedef struct packed {
		logic       occ;
		logic [2:0] cmd;
	} cell_ctrl_t;

	typedef struct packed {
		logic hit;
		logic locked;
	} cell_stat_t;

endpackage

/* sv/rtfl_cell.sv */
module rtfl_cell import rtfl_pkg::*; (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [TILE_W-1:0] query,
	input  entry_t            next_entry,
	input  entry_t            head_entry,
	input  entry_t            new_entry,
	output entry_t            entry,
	output cell_stat_t        stat
);

	entry_t entry_q;

	// Slot update: shift from neighbour, wrap from the front, load or unlock
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CELL_NEXT:   entry_q <= next_entry;
			CELL_HEAD:   entry_q <= head_entry;
			CELL_NEW:    entry_q <= new_entry;
			CELL_UNLOCK: begin
				if (stat.hit) begin
					entry_q.locked <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Lookup against the incoming tile index
	assign stat.hit    = ctrl.occ && (entry_q.tile == query);
	assign stat.locked = entry_q.locked;
	assign entry       = entry_q;

endmodule

/* sv/resident_tile_fifo_with_locks.sv */
// Hit, release, flush, out-of-range, busy and non-evicting loads register their result in
//   the cycle after the request is taken, one per cycle while no result is stalled.
// An evicting load rotates locked front entries to the back (at most MAX_RESIDENT - 1),
//   then evicts the front entry and appends the new tile; no request is taken meanwhile.
// Reset (arst_n low, asynchronous) empties the queue, drops any pending result and
//   sets tile_count and capacity to 1.
module resident_tile_fifo_with_locks import rtfl_pkg::*; #(
	parameter int MAX_TILES    = 1024,
	parameter int MAX_RESIDENT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FILL_W = $clog2(MAX_RESIDENT + 1);
	localparam int CMP_W  = (FILL_W > CAP_CFG_W) ? FILL_W : CAP_CFG_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_ROT  = 1'b1;

	logic                 state_q;
	logic [FILL_W-1:0]    fill_q;
	logic [FILL_W-1:0]    fill_m1;
	entry_t               pend_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [COUNT_W-1:0]   tile_count_q;
	logic [CAP_CFG_W-1:0] capacity_q;

	cell_ctrl_t ctrl   [MAX_RESIDENT];
	entry_t     cell_e [MAX_RESIDENT];
	cell_stat_t stat   [MAX_RESIDENT];
	entry_t     new_entry;

	logic             out_free, accept;
	logic             in_range, any_hit, hit_locked, all_locked, full;
	logic [CMP_W-1:0] cap_eff;
	logic             is_req, load_direct, load_evict, emit_idle, emit_rot, front_locked;
	rsp_t             idle_rsp;

	// Handshake
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;

	// Range and capacity checks
	assign in_range = ({1'b0, req.tile_index} < tile_count_q) &&
		(32'(req.tile_index) < 32'(MAX_TILES));
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(MAX_RESIDENT)) begin
			cap_eff = CMP_W'(MAX_RESIDENT);
		end else begin
			cap_eff = CMP_W'(capacity_q);
		end
	end
	assign full    = CMP_W'(fill_q) >= cap_eff;
	assign fill_m1 = fill_q - FILL_W'(1);

	// Reduce cell lookups
	always_comb begin
		any_hit    = 1'b0;
		hit_locked = 1'b0;
		all_locked = 1'b1;
		for (int i = 0; i < MAX_RESIDENT; i++) begin
			any_hit    = any_hit | stat[i].hit;
			hit_locked = hit_locked | (stat[i].hit & stat[i].locked);
			if (ctrl[i].occ && !stat[i].locked) begin
				all_locked = 1'b0;
			end
		end
	end

	assign front_locked = cell_e[0].locked;
	assign is_req       = accept && (req.mode == MODE_REQUEST) && in_range && !any_hit;
	assign load_direct  = is_req && !full;
	assign load_evict   = is_req && full && !all_locked;
	assign emit_idle    = accept && !load_evict;
	assign emit_rot     = (state_q == S_ROT) && !front_locked && out_free;
	assign new_entry    = (state_q == S_ROT) ? pend_q : entry_t'{req.tile_index, req.lock};

	// Per-cell commands
	always_comb begin
		for (int i = 0; i < MAX_RESIDENT; i++) begin
			ctrl[i].occ = FILL_W'(i) < fill_q;
			ctrl[i].cmd = CELL_KEEP;
			if (state_q == S_ROT) begin
				if (FILL_W'(i) < fill_m1) begin
					if (front_locked || out_free) begin
						ctrl[i].cmd = CELL_NEXT;
					end
				end else if (FILL_W'(i) == fill_m1) begin
					if (front_locked) begin
						ctrl[i].cmd = CELL_HEAD;
					end else if (out_free) begin
						ctrl[i].cmd = CELL_NEW;
					end
				end
			end else if (accept && (req.mode == MODE_RELEASE) && in_range) begin
				ctrl[i].cmd = CELL_UNLOCK;
			end else if (load_direct && (FILL_W'(i) == fill_q)) begin
				ctrl[i].cmd = CELL_NEW;
			end
		end
	end

	// Chain of queue cells, front at index 0
	for (genvar g = 0; g < MAX_RESIDENT; g++) begin : g_cell
		entry_t nxt;
		if (g == MAX_RESIDENT - 1) begin : g_last
			assign nxt = cell_e[g];
		end else begin : g_mid
			assign nxt = cell_e[g+1];
		end
		rtfl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[g]),
			.query      (req.tile_index),
			.next_entry (nxt),
			.head_entry (cell_e[0]),
			.new_entry  (new_entry),
			.entry      (cell_e[g]),
			.stat       (stat[g])
		);
	end

	// Result of a request finished in the accept cycle
	always_comb begin
		idle_rsp = '0;
		case (req.mode)
			MODE_RELEASE: idle_rsp.status = in_range ? ST_HIT : ST_RANGE;
			MODE_REQUEST: begin
				if (!in_range) begin
					idle_rsp.status = ST_RANGE;
				end else if (hit_locked) begin
					idle_rsp.status = ST_BUSY;
				end else if (any_hit) begin
					idle_rsp.status = ST_HIT;
				end else if (full) begin
					idle_rsp.status = ST_NO_VICTIM;
				end else begin
					idle_rsp.status = ST_LOADED;
				end
			end
			default: idle_rsp.status = ST_HIT;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			rsp_valid_q  <= 1'b0;
			tile_count_q <= COUNT_W'(1);
			capacity_q   <= CAP_CFG_W'(1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TILE_COUNT: tile_count_q <= cfg_data;
					REG_CAPACITY:   capacity_q   <= cfg_data[CAP_CFG_W-1:0];
					default: ;
				endcase
			end
			rsp_valid_q <= emit_idle || emit_rot || (rsp_valid_q && rsp_stall);
			if (state_q == S_ROT) begin
				if (emit_rot) begin
					state_q <= S_IDLE;
				end
			end else if (load_evict) begin
				state_q <= S_ROT;
			end
			if (accept && (req.mode == MODE_FLUSH)) begin
				fill_q <= '0;
			end else if (load_direct) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Pending load and result payload
	always_ff @(posedge clk) begin
		if (load_evict) begin
			pend_q <= entry_t'{req.tile_index, req.lock};
		end
		if (emit_idle) begin
			rsp_q <= idle_rsp;
		end else if (emit_rot) begin
			rsp_q <= rsp_t'{ST_LOADED, 1'b1, cell_e[0].tile};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Queue never holds more entries than cells
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= MAX_RESIDENT)
		else $error("queue fill beyond cell count");

	// Eviction only starts with a full queue holding an unlocked entry
	a_rot_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && load_evict) |=> (state_q == S_ROT && fill_q != '0))
		else $error("eviction started on an empty queue");

	// Eviction plus insertion keeps the fill unchanged
	a_rot_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |=> (fill_q == $past(fill_q)))
		else $error("fill changed during eviction");

	// An evicted tile is only reported with a load
	a_evict_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.evicted_valid) |-> (rsp_q.status == ST_LOADED))
		else $error("eviction reported without a load");

	// No request taken while an eviction is under way
	a_rot_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |-> req_stall)
		else $error("request taken during eviction");

endmodule
